// File: sv/sapq_pkg.sv
// Shared types and constants for the sorted array priority queue.
// No dependencies; every other file imports this package.
package sapq_pkg;

    localparam int DEPTH       = 8;
    localparam int VAL_W       = 32;
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int ENTRY_CNT_W = 4;
    localparam int STATUS_W    = 2;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_DELETE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_OVERFLOW  = 2'd1,
        STAT_UNDERFLOW = 2'd2,
        STAT_NOT_FOUND = 2'd3
    } t_status;

    typedef enum logic {
        S_IDLE,
        S_HOLD
    } t_state;

    typedef struct packed {
        logic exec;
    } t_dp_cmd;

endpackage

// File: sv/sapq_ctrl.sv
// Handshake controller for the sorted array priority queue.
// Depends on sapq_pkg; issues the execute command to sapq_dp.
module sapq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output sapq_pkg::t_dp_cmd o_cmd
);
    import sapq_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign accept = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_HOLD;
                end
            end
            S_HOLD: begin
                if (accept) begin
                    n_state = S_HOLD;
                end else if (!i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall  = 1'b0;
        o_out_valid = 1'b0;
        o_cmd.exec  = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_cmd.exec = i_in_valid;
            end
            S_HOLD: begin
                o_out_valid = 1'b1;
                o_in_stall  = i_out_stall;
                o_cmd.exec  = i_in_valid && !i_out_stall;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

endmodule

// File: sv/sapq_dp.sv
// Datapath of the sorted array priority queue: sorted cells, count and result registers.
// Depends on sapq_pkg; driven by the execute command from sapq_ctrl.
module sapq_dp (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  sapq_pkg::t_dp_cmd                      i_cmd,
    input  logic                                   i_command,
    input  logic signed [sapq_pkg::VAL_W-1:0]      i_value,
    output logic [sapq_pkg::STATUS_W-1:0]          o_status,
    output logic signed [sapq_pkg::VAL_W-1:0]      o_head_value,
    output logic [sapq_pkg::ENTRY_CNT_W-1:0]       o_entry_count
);
    import sapq_pkg::*;

    logic signed [VAL_W-1:0] r_entries [DEPTH];
    logic signed [VAL_W-1:0] n_entries [DEPTH];
    logic signed [VAL_W-1:0] dn_entries [DEPTH];
    logic signed [VAL_W-1:0] up_entries [DEPTH];
    logic [CNT_W-1:0]        r_count;
    logic [CNT_W-1:0]        n_count;
    t_status                 r_status;
    t_status                 n_status;
    logic signed [VAL_W-1:0] r_head;
    logic signed [VAL_W-1:0] n_head;
    logic [DEPTH-1:0]        live;
    logic [DEPTH-1:0]        ins_hit;
    logic [DEPTH-1:0]        del_hit;
    logic [DEPTH-1:0]        ins_pre;
    logic [DEPTH-1:0]        del_pre;
    logic                    full;
    logic                    empty;
    logic                    found;

    assign full  = (r_count == CNT_W'(DEPTH));
    assign empty = (r_count == '0);
    assign found = (del_hit != '0);

    always_comb begin
        dn_entries[0]       = i_value;
        up_entries[DEPTH-1] = r_entries[DEPTH-1];
        for (int k = 1; k < DEPTH; k++) begin
            dn_entries[k]   = r_entries[k-1];
            up_entries[k-1] = r_entries[k];
        end
    end

    always_comb begin
        for (int k = 0; k < DEPTH; k++) begin
            live[k]    = (CNT_W'(k) < r_count);
            ins_hit[k] = live[k] && (i_value >= r_entries[k]);
            del_hit[k] = live[k] && (i_value == r_entries[k]);
        end
        for (int k = 0; k < DEPTH; k++) begin
            ins_pre[k] = ((ins_hit & ((DEPTH'(1) << k) - DEPTH'(1))) != '0);
            del_pre[k] = ((del_hit & ((DEPTH'(1) << k) - DEPTH'(1))) != '0);
        end
    end

    always_comb begin
        n_entries = r_entries;
        n_count   = r_count;
        n_status  = STAT_OK;
        if (i_command == CMD_INSERT) begin
            if (full) begin
                n_status = STAT_OVERFLOW;
            end else begin
                for (int k = 0; k < DEPTH; k++) begin
                    if (ins_pre[k]) begin
                        n_entries[k] = dn_entries[k];
                    end else if (ins_hit[k] || (CNT_W'(k) == r_count)) begin
                        n_entries[k] = i_value;
                    end
                end
                n_count = r_count + CNT_W'(1);
            end
        end else begin
            if (empty) begin
                n_status = STAT_UNDERFLOW;
            end else if (!found) begin
                n_status = STAT_NOT_FOUND;
            end else begin
                for (int k = 0; k < DEPTH; k++) begin
                    if (del_pre[k] || del_hit[k]) begin
                        n_entries[k] = up_entries[k];
                    end
                end
                n_count = r_count - CNT_W'(1);
            end
        end
        n_head = (n_count != '0) ? n_entries[0] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_entries <= n_entries;
            r_status  <= n_status;
            r_head    <= n_head;
        end
    end

    assign o_status      = r_status;
    assign o_head_value  = r_head;
    assign o_entry_count = ENTRY_CNT_W'(r_count);

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count beyond capacity");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $past(i_cmd.exec) && r_status == STAT_OK
            && $past(i_command) == CMD_INSERT)
        |-> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("insert did not grow the queue by one");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $past(i_cmd.exec) && r_status == STAT_OK
            && $past(i_command) == CMD_DELETE)
        |-> (r_count == $past(r_count) - CNT_W'(1)))
        else $error("delete did not shrink the queue by one");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $past(i_cmd.exec) && r_status != STAT_OK)
        |-> (r_count == $past(r_count)))
        else $error("rejected transaction changed the count");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $past(i_cmd.exec) && r_count == '0)
        |-> (r_head == '0))
        else $error("empty queue reports a nonzero head");

endmodule

// File: sv/sorted_array_priority_queue_top.sv
// Bounded priority queue of sapq_pkg::DEPTH signed entries kept largest first.
// Every cell compares the incoming value in parallel and shifts by at most
// one place, so an insert or delete completes without iteration: the result is
// registered and shown in the cycle after the input transaction is taken, and a new
// transaction is taken every cycle unless a held result is stalled. No clearing
// pass follows reset. Depends on sapq_pkg, sapq_ctrl and sapq_dp.
module sorted_array_priority_queue_top (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic                                   i_command,
    input  logic signed [sapq_pkg::VAL_W-1:0]      i_value,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic [sapq_pkg::STATUS_W-1:0]          o_status,
    output logic signed [sapq_pkg::VAL_W-1:0]      o_head_value,
    output logic [sapq_pkg::ENTRY_CNT_W-1:0]       o_entry_count
);
    import sapq_pkg::*;

    t_dp_cmd dp_cmd;

    sapq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (dp_cmd)
    );

    sapq_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .i_command     (i_command),
        .i_value       (i_value),
        .o_status      (o_status),
        .o_head_value  (o_head_value),
        .o_entry_count (o_entry_count)
    );

endmodule

// File: tb/sapq_checker.sv
// Scoreboard for the sorted array priority queue: watches both channels,
// keeps a shadow copy of the sorted entries and compares every result.
// Depends on sapq_pkg.
module sapq_checker (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    input  logic                                   i_in_stall,
    input  logic                                   i_command,
    input  logic signed [sapq_pkg::VAL_W-1:0]      i_value,
    input  logic                                   i_out_valid,
    input  logic                                   i_out_stall,
    input  logic [sapq_pkg::STATUS_W-1:0]          i_status,
    input  logic signed [sapq_pkg::VAL_W-1:0]      i_head_value,
    input  logic [sapq_pkg::ENTRY_CNT_W-1:0]       i_entry_count,
    output int                                     o_fail_count,
    output int                                     o_pending
);
    import sapq_pkg::*;

    typedef struct packed {
        t_status                   status;
        logic signed [VAL_W-1:0]   head;
        logic [ENTRY_CNT_W-1:0]    count;
    } t_queue_report;

    logic signed [VAL_W-1:0] shadow_entries [DEPTH];
    int                      shadow_count = 0;
    t_queue_report           queued_reports [$];
    int                      fails = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic t_queue_report step_queue(logic cmd, logic signed [VAL_W-1:0] val);
        t_queue_report rep;
        int            pos;
        rep.status = STAT_OK;
        if (cmd == CMD_INSERT) begin
            if (shadow_count >= DEPTH) begin
                rep.status = STAT_OVERFLOW;
            end else begin
                pos = shadow_count;
                for (int k = shadow_count - 1; k >= 0; k--) begin
                    if (val >= shadow_entries[k]) pos = k;
                end
                for (int k = shadow_count; k > pos; k--) begin
                    shadow_entries[k] = shadow_entries[k-1];
                end
                shadow_entries[pos] = val;
                shadow_count++;
            end
        end else begin
            if (shadow_count == 0) begin
                rep.status = STAT_UNDERFLOW;
            end else begin
                pos = shadow_count;
                for (int k = shadow_count - 1; k >= 0; k--) begin
                    if (shadow_entries[k] == val) pos = k;
                end
                if (pos == shadow_count) begin
                    rep.status = STAT_NOT_FOUND;
                end else begin
                    for (int k = pos; k + 1 < shadow_count; k++) begin
                        shadow_entries[k] = shadow_entries[k+1];
                    end
                    shadow_count--;
                end
            end
        end
        rep.head  = (shadow_count > 0) ? shadow_entries[0] : '0;
        rep.count = shadow_count[ENTRY_CNT_W-1:0];
        return rep;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_queue_report due;
        if (!i_rst_n) begin
            shadow_count = 0;
            queued_reports.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (queued_reports.size() == 0) begin
                    fails++;
                    $error("unexpected result: status %0d head_value %0d entry_count %0d",
                           i_status, i_head_value, i_entry_count);
                end else begin
                    due = queued_reports.pop_front();
                    if (i_status !== due.status) begin
                        fails++;
                        $error("status: expected %0d, actual %0d", due.status, i_status);
                    end
                    if (i_head_value !== due.head) begin
                        fails++;
                        $error("head_value: expected %0d, actual %0d",
                               $signed(due.head), i_head_value);
                    end
                    if (i_entry_count !== due.count) begin
                        fails++;
                        $error("entry_count: expected %0d, actual %0d",
                               due.count, i_entry_count);
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                queued_reports.push_back(step_queue(i_command, i_value));
            end
        end
        o_fail_count <= fails;
        o_pending    <= queued_reports.size();
    end

endmodule

// File: tb/tb.sv
// Top of the priority queue testbench: clock, reset, directed and random
// insert/delete traffic, output stalls and the verdict.
// Depends on sapq_pkg, sorted_array_priority_queue_top and sapq_checker.
module tb;
    import sapq_pkg::*;

    localparam int LIMIT        = 400000;
    localparam int HOLD_CYCLES  = 80;
    localparam int PHASES       = 17;
    localparam int PHASE_ITEMS  = 50;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_in_valid;
    logic                        o_in_stall;
    logic                        i_command;
    logic signed [VAL_W-1:0]     i_value;
    logic                        o_out_valid;
    logic                        i_out_stall;
    logic [STATUS_W-1:0]         o_status;
    logic signed [VAL_W-1:0]     o_head_value;
    logic [ENTRY_CNT_W-1:0]      o_entry_count;

    int                          fail_count;
    int                          pending;
    int                          hold_asked = 0;
    bit                          steady_in  = 0;
    bit                          steady_out = 0;
    int                          cycle_count = 0;
    logic signed [VAL_W-1:0]     recent_values [$];

    sorted_array_priority_queue_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_command     (i_command),
        .i_value       (i_value),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_head_value  (o_head_value),
        .o_entry_count (o_entry_count)
    );

    sapq_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_command     (i_command),
        .i_value       (i_value),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_status      (o_status),
        .i_head_value  (o_head_value),
        .i_entry_count (o_entry_count),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    function automatic logic signed [VAL_W-1:0] pick_value();
        int r;
        int v;
        r = $urandom_range(0, 9);
        if (r < 4) begin
            v = int'($urandom_range(0, 8)) - 4;
        end else if (r < 6 && recent_values.size() > 0) begin
            v = recent_values[$urandom_range(0, recent_values.size() - 1)];
        end else if (r == 6) begin
            case ($urandom_range(0, 3))
                0: v = 32'sh7FFF_FFFF;
                1: v = 32'sh8000_0000;
                2: v = 0;
                default: v = -1;
            endcase
        end else begin
            v = $urandom;
        end
        return v;
    endfunction

    task automatic send_item(logic cmd, logic signed [VAL_W-1:0] val);
        int gap;
        i_in_valid <= 1'b1;
        i_command  <= cmd;
        i_value    <= val;
        do @(posedge i_clk); while (o_in_stall);
        if (cmd == CMD_INSERT) begin
            recent_values.push_back(val);
            if (recent_values.size() > 16) void'(recent_values.pop_front());
        end
        gap = steady_in ? 0 : pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic send_random(int mode);
        logic                    cmd;
        logic signed [VAL_W-1:0] val;
        int                      idx;
        int                      pct;
        pct = (mode == 0) ? 70 : (mode == 1) ? 30 : 50;
        cmd = ($urandom_range(0, 99) < pct) ? CMD_INSERT : CMD_DELETE;
        if (cmd == CMD_DELETE && recent_values.size() > 0 && $urandom_range(0, 9) < 6) begin
            idx = $urandom_range(0, recent_values.size() - 1);
            val = recent_values[idx];
            recent_values.delete(idx);
        end else begin
            val = pick_value();
        end
        send_item(cmd, val);
    endtask

    initial begin
        int n;
        i_out_stall = 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_asked != 0) begin
                hold_asked  <= 0;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                n = steady_out ? 0 : pick_gap();
                if (n > 0) begin
                    i_out_stall <= 1'b1;
                    repeat (n) @(posedge i_clk);
                end
                i_out_stall <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
        end
    end

    initial begin
        while (cycle_count < LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("sorted_array_priority_queue_top test failed");
        $finish;
    end

    initial begin
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_command  = CMD_INSERT;
        i_value    = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty queue, fill with extremes and equal values, overflow, miss, drain
        send_item(CMD_DELETE, 5);
        send_item(CMD_INSERT, 32'sh7FFF_FFFF);
        send_item(CMD_INSERT, 32'sh8000_0000);
        send_item(CMD_INSERT, 0);
        send_item(CMD_INSERT, 0);
        send_item(CMD_INSERT, -1);
        send_item(CMD_INSERT, 1);
        send_item(CMD_INSERT, 100);
        send_item(CMD_INSERT, 100);
        send_item(CMD_INSERT, 7);
        send_item(CMD_DELETE, 12345);
        send_item(CMD_DELETE, 32'sh7FFF_FFFF);
        send_item(CMD_DELETE, 32'sh8000_0000);
        send_item(CMD_DELETE, 0);
        send_item(CMD_DELETE, 0);
        send_item(CMD_DELETE, -1);
        send_item(CMD_DELETE, 1);
        send_item(CMD_DELETE, 100);
        send_item(CMD_DELETE, 100);
        send_item(CMD_DELETE, 100);
        send_item(CMD_INSERT, 32'sh5555_5555);
        send_item(CMD_INSERT, 32'shAAAA_AAAA);
        send_item(CMD_DELETE, 32'sh5555_5555);
        send_item(CMD_DELETE, 32'shAAAA_AAAA);
        recent_values.delete();

        for (int p = 0; p < PHASES; p++) begin
            steady_in  = (p % 4 == 3) || (p == 2);
            steady_out = (p % 4 == 3);
            if (p == 2) hold_asked <= 1;
            if (p == 5 || p == 11) drain_results();
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                send_random(p % 3);
            end
        end

        drain_results();
        repeat (10) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("sorted_array_priority_queue_top test passed");
        end else begin
            $display("sorted_array_priority_queue_top test failed");
        end
        $finish;
    end

endmodule
